### sv/psf_pkg.sv
// psf_pkg: shared types, constants and arithmetic helpers of the separation force core
// no dependencies; imported by psf_front, psf_div, psf_back and the top level
`default_nettype none

package psf_pkg;

  // default configuration of the top level
  localparam int unsigned NUM_BOIDS_DEF = 64;
  localparam int unsigned POS_WIDTH_DEF = 32;

  // fixed field widths
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned IDX_EXT_W = 13;
  localparam int unsigned IN_POS_W  = 32;
  localparam int unsigned GAIN_W    = 32;
  localparam int unsigned FRC_W     = 48;
  localparam int unsigned MAG_W     = 17;
  localparam int unsigned NUM_W     = 49;
  localparam int unsigned QSUM_W    = 35;

  // constants of the force law
  localparam logic [GAIN_W-1:0]        GAIN_RESET = 32'd65536;
  localparam logic [FRC_W-1:0]         TERM_CAP   = 48'd65536000;
  localparam logic [FRC_W-1:0]         MAG_SAT    = 48'h8000_0000_0000;
  localparam int unsigned              UNIT_SEP   = 65536;
  localparam logic [QSUM_W-1:0]        Q_LIMIT    = 35'h1_0000_0000;
  localparam logic signed [FRC_W+1:0]  FRC_MAX    = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [FRC_W+1:0]  FRC_MIN    = -50'sh8000_0000_0000;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // one classified transaction as it sits in the command queue
  typedef struct packed {
    func_t                func;
    logic                 in_range;
    logic [IDX_W-1:0]     boid_index;
    logic [IN_POS_W-1:0]  pos_x;
    logic [IN_POS_W-1:0]  pos_y;
    logic [IN_POS_W-1:0]  pos_z;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_RD_I,
    ST_LAT_I,
    ST_RD_J,
    ST_DIFF,
    ST_CHK,
    ST_SQ,
    ST_QCHK,
    ST_SQRT,
    ST_CUBE1,
    ST_CUBE2,
    ST_DIV,
    ST_DIV_WAIT,
    ST_ACC,
    ST_OUT
  } back_state_t;

  // signed axis term from the quotient magnitude
  function automatic logic signed [FRC_W:0] axis_term(input logic neg,
                                                      input logic [FRC_W-1:0] m);
    logic [FRC_W-1:0] capped;
    capped = (m > TERM_CAP) ? TERM_CAP : m;
    if (neg) begin
      axis_term = $signed({1'b0, capped});
    end else begin
      axis_term = -$signed({1'b0, m});
    end
  endfunction

  // saturating accumulate into the force range
  function automatic logic signed [FRC_W-1:0] sat_add(input logic signed [FRC_W-1:0] a,
                                                      input logic signed [FRC_W:0] b);
    logic signed [FRC_W+1:0] sum;
    sum = (FRC_W+2)'(a) + (FRC_W+2)'(b);
    if (sum > FRC_MAX) begin
      sat_add = FRC_MAX[FRC_W-1:0];
    end else if (sum < FRC_MIN) begin
      sat_add = FRC_MIN[FRC_W-1:0];
    end else begin
      sat_add = sum[FRC_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### sv/psf_ram.sv
// psf_ram: generic single write port, single read port memory with registered read
// no dependencies
`default_nettype none

module psf_ram #(
  parameter int unsigned WIDTH = 96,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### sv/psf_front.sv
// psf_front: accepts transactions, classifies them and queues them for the back end
// depends on psf_pkg
`default_nettype none

module psf_front
  import psf_pkg::*;
#(
  parameter int unsigned NUM_BOIDS = NUM_BOIDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_func,
  input  wire logic [IDX_W-1:0]    in_boid_index,
  input  wire logic [IN_POS_W-1:0] in_pos_x,
  input  wire logic [IN_POS_W-1:0] in_pos_y,
  input  wire logic [IN_POS_W-1:0] in_pos_z,
  output logic                     cmd_valid,
  output cmd_t                     cmd,
  input  wire logic                cmd_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  cmd_t       cmd_in;

  // classify the incoming transaction
  always_comb begin
    cmd_in.func       = func_t'(in_func);
    cmd_in.in_range   = ({(IDX_EXT_W-IDX_W)'(0), in_boid_index} < IDX_EXT_W'(NUM_BOIDS));
    cmd_in.boid_index = in_boid_index;
    cmd_in.pos_x      = in_pos_x;
    cmd_in.pos_y      = in_pos_y;
    cmd_in.pos_z      = in_pos_z;
  end

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

### sv/psf_div.sv
// psf_div: bit-serial divider giving min(floor(num * 2^32 / den), 2^47)
// depends on psf_pkg
`default_nettype none

module psf_div
  import psf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [NUM_W-1:0] den,
  output logic                  done,
  output logic [FRC_W-1:0]      quo
);

  localparam int unsigned SH_W = FRC_W - 1;

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [FRC_W-1:0] quo_r, quo_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [NUM_W:0]   trial;
  logic             sat;

  assign sat   = ({15'b0, num} >= {den, 15'b0});
  assign trial = {rem_r, sh_r[SH_W-1]};
  assign done  = done_r;
  assign quo   = quo_r;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = done_r;
    if (start) begin
      if (sat) begin
        quo_nxt  = MAG_SAT;
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = NUM_W'(num[NUM_W-1:15]);
        sh_nxt   = {num[14:0], 32'b0};
        quo_nxt  = '0;
        cnt_nxt  = 6'(SH_W - 1);
        run_nxt  = 1'b1;
        done_nxt = 1'b0;
      end
    end else if (run_r) begin
      if (trial >= {1'b0, den}) begin
        rem_nxt = NUM_W'(trial - {1'b0, den});
        quo_nxt = {quo_r[FRC_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[NUM_W-1:0];
        quo_nxt = {quo_r[FRC_W-2:0], 1'b0};
      end
      sh_nxt = {sh_r[SH_W-2:0], 1'b0};
      if (cnt_r == 6'd0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    quo_r <= quo_nxt;
  end

endmodule

`default_nettype wire

### sv/psf_back.sv
// psf_back: executes queued transactions, holds the position store and walks neighbours
// depends on psf_pkg, psf_ram, psf_div
`default_nettype none

module psf_back
  import psf_pkg::*;
#(
  parameter int unsigned NUM_BOIDS = NUM_BOIDS_DEF,
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cmd_valid,
  input  wire cmd_t                cmd,
  output logic                     cmd_pop,
  input  wire logic [GAIN_W-1:0]   gain,
  output logic                     out_valid,
  output logic signed [FRC_W-1:0]  out_force_x,
  output logic signed [FRC_W-1:0]  out_force_y,
  output logic signed [FRC_W-1:0]  out_force_z
);

  localparam int unsigned AW = $clog2(NUM_BOIDS);
  localparam int unsigned SW = POS_WIDTH + 2;
  localparam logic [AW-1:0] LAST = AW'(NUM_BOIDS - 1);
  localparam logic signed [SW-1:0] SEP_P = SW'(UNIT_SEP);
  localparam logic signed [SW-1:0] SEP_N = -SEP_P;

  back_state_t state_r, state_nxt;
  cmd_t        cmd_r;
  logic [AW-1:0] j_r, j_nxt;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [AW-1:0] idx;

  logic signed [POS_WIDTH-1:0] pix_r, piy_r, piz_r;
  logic signed [POS_WIDTH-1:0] rjx, rjy, rjz;
  logic signed [POS_WIDTH-1:0] wx, wy, wz;
  logic signed [SW-1:0] sx_r, sy_r, sz_r;
  logic self_r;
  logic [MAG_W-1:0] mx_r, my_r, mz_r;
  logic nx_r, ny_r, nz_r;
  logic [33:0] sqx, sqy, sqz;
  logic [QSUM_W-1:0] q_r;
  logic [32:0] sqv_r, sqv_nxt;
  logic [33:0] sqr_r, sqr_nxt, sqb_r, sqb_nxt, sq_trial;
  logic [4:0]  scnt_r, scnt_nxt;
  logic [MAG_W-1:0] d_w;
  logic [33:0] d2_r;
  logic [50:0] cube_full;
  logic [NUM_W-1:0] cube_r;
  logic [NUM_W-1:0] numx_r, numy_r, numz_r;
  logic [NUM_W-1:0] numx_w, numy_w, numz_w;
  logic signed [FRC_W-1:0] accx_r, accy_r, accz_r;
  logic out_of_range;

  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [3*POS_WIDTH-1:0] ram_rdata;

  logic div_start;
  logic dx_done, dy_done, dz_done;
  logic [FRC_W-1:0] qx, qy, qz;

  assign idx_ext = IDX_EXT_W'(cmd_r.boid_index);
  assign idx     = idx_ext[AW-1:0];

  // positions narrowed or sign-extended to the store width
  assign wx = POS_WIDTH'($signed(cmd_r.pos_x));
  assign wy = POS_WIDTH'($signed(cmd_r.pos_y));
  assign wz = POS_WIDTH'($signed(cmd_r.pos_z));

  assign ram_we    = (state_r == ST_WRITE) && cmd_r.in_range;
  assign ram_raddr = (state_r == ST_RD_I) ? idx : j_r;

  psf_ram #(
    .WIDTH (3 * POS_WIDTH),
    .DEPTH (NUM_BOIDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({wx, wy, wz}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rjx = ram_rdata[3*POS_WIDTH-1:2*POS_WIDTH];
  assign rjy = ram_rdata[2*POS_WIDTH-1:POS_WIDTH];
  assign rjz = ram_rdata[POS_WIDTH-1:0];

  // separation range test
  assign out_of_range = (sx_r > SEP_P) || (sx_r < SEP_N) || (sy_r > SEP_P) ||
                        (sy_r < SEP_N) || (sz_r > SEP_P) || (sz_r < SEP_N);

  // squared distance, cube and numerators
  assign sqx       = mx_r * mx_r;
  assign sqy       = my_r * my_r;
  assign sqz       = mz_r * mz_r;
  assign d_w       = sqr_r[MAG_W-1:0];
  assign cube_full = d2_r * d_w;
  assign numx_w    = gain * mx_r;
  assign numy_w    = gain * my_r;
  assign numz_w    = gain * mz_r;
  assign sq_trial  = sqr_r + sqb_r;

  assign div_start = (state_r == ST_DIV);

  psf_div u_div_x (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numx_r),
                   .den(cube_r), .done(dx_done), .quo(qx));
  psf_div u_div_y (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numy_r),
                   .den(cube_r), .done(dy_done), .quo(qy));
  psf_div u_div_z (.clk(clk), .rst_n(rst_n), .start(div_start), .num(numz_r),
                   .den(cube_r), .done(dz_done), .quo(qz));

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    cmd_pop   = 1'b0;
    sqv_nxt   = sqv_r;
    sqr_nxt   = sqr_r;
    sqb_nxt   = sqb_r;
    scnt_nxt  = scnt_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (cmd.func == FUNC_WRITE) begin
            state_nxt = ST_WRITE;
          end else if (cmd.in_range) begin
            state_nxt = ST_RD_I;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_WRITE:  state_nxt = ST_IDLE;
      ST_RD_I:   state_nxt = ST_LAT_I;
      ST_LAT_I: begin
        j_nxt     = '0;
        state_nxt = ST_RD_J;
      end
      ST_RD_J:   state_nxt = ST_DIFF;
      ST_DIFF:   state_nxt = ST_CHK;
      ST_CHK: begin
        if (self_r || out_of_range) begin
          if (j_r == LAST) begin
            state_nxt = ST_OUT;
          end else begin
            j_nxt     = j_r + AW'(1);
            state_nxt = ST_RD_J;
          end
        end else begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:     state_nxt = ST_QCHK;
      ST_QCHK: begin
        if ((q_r == '0) || (q_r > Q_LIMIT)) begin
          if (j_r == LAST) begin
            state_nxt = ST_OUT;
          end else begin
            j_nxt     = j_r + AW'(1);
            state_nxt = ST_RD_J;
          end
        end else begin
          sqv_nxt   = q_r[32:0];
          sqr_nxt   = '0;
          sqb_nxt   = 34'h1_0000_0000;
          scnt_nxt  = 5'd16;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // one digit pair of the integer square root per cycle
        if ({1'b0, sqv_r} >= sq_trial) begin
          sqv_nxt = 33'({1'b0, sqv_r} - sq_trial);
          sqr_nxt = (sqr_r >> 1) + sqb_r;
        end else begin
          sqr_nxt = sqr_r >> 1;
        end
        sqb_nxt = sqb_r >> 2;
        if (scnt_r == 5'd0) begin
          state_nxt = ST_CUBE1;
        end else begin
          scnt_nxt = scnt_r - 5'd1;
        end
      end
      ST_CUBE1:  state_nxt = ST_CUBE2;
      ST_CUBE2:  state_nxt = ST_DIV;
      ST_DIV:    state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (dx_done && dy_done && dz_done) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (j_r == LAST) begin
          state_nxt = ST_OUT;
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_RD_J;
        end
      end
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    sqv_r  <= sqv_nxt;
    sqr_r  <= sqr_nxt;
    sqb_r  <= sqb_nxt;
    scnt_r <= scnt_nxt;
    if (cmd_pop) begin
      cmd_r <= cmd;
      if (cmd.func == FUNC_QUERY) begin
        accx_r <= '0;
        accy_r <= '0;
        accz_r <= '0;
      end
    end
    if (state_r == ST_LAT_I) begin
      pix_r <= rjx;
      piy_r <= rjy;
      piz_r <= rjz;
    end
    if (state_r == ST_DIFF) begin
      sx_r   <= SW'(rjx) - SW'(pix_r);
      sy_r   <= SW'(rjy) - SW'(piy_r);
      sz_r   <= SW'(rjz) - SW'(piz_r);
      self_r <= (j_r == idx);
    end
    if (state_r == ST_CHK) begin
      nx_r <= sx_r[SW-1];
      ny_r <= sy_r[SW-1];
      nz_r <= sz_r[SW-1];
      mx_r <= sx_r[SW-1] ? MAG_W'(-sx_r) : MAG_W'(sx_r);
      my_r <= sy_r[SW-1] ? MAG_W'(-sy_r) : MAG_W'(sy_r);
      mz_r <= sz_r[SW-1] ? MAG_W'(-sz_r) : MAG_W'(sz_r);
    end
    if (state_r == ST_SQ) begin
      q_r <= QSUM_W'(sqx) + QSUM_W'(sqy) + QSUM_W'(sqz);
    end
    if (state_r == ST_CUBE1) begin
      d2_r   <= d_w * d_w;
      numx_r <= numx_w;
      numy_r <= numy_w;
      numz_r <= numz_w;
    end
    if (state_r == ST_CUBE2) begin
      cube_r <= cube_full[NUM_W-1:0];
    end
    if (state_r == ST_ACC) begin
      accx_r <= sat_add(accx_r, axis_term(nx_r, qx));
      accy_r <= sat_add(accy_r, axis_term(ny_r, qy));
      accz_r <= sat_add(accz_r, axis_term(nz_r, qz));
    end
  end

  assign out_valid   = (state_r == ST_OUT);
  assign out_force_x = accx_r;
  assign out_force_y = accy_r;
  assign out_force_z = accz_r;

endmodule

`default_nettype wire

### sv/pairwise_separation_force_core.sv
// pairwise_separation_force_core: top level of the boid separation force block
// depends on psf_pkg, psf_front, psf_back (and through it psf_ram, psf_div)
`default_nettype none
//
// Usage:
//   Input channel: a transaction is taken when start is high and busy is low.
//   in_func selects a position write or a force query on in_boid_index. A
//   two-entry command queue sits in front of the execution engine, so busy
//   rises only when that queue is full.
//   Result channel: each query gives one result, shown on out_force_* for
//   exactly one cycle with out_valid high. The receiver cannot stall it.
//   Writes give no result. A query on an index at or above NUM_BOIDS returns
//   zero force.
//   Configuration: cfg_data is written to the repulsion gain when cfg_valid is
//   high; cfg_ready is always high. Write it only while the block is idle.
//   Timing: a write passes through the engine's write state. A query reads its
//   own position and then walks every neighbour: a self or out-of-box one is
//   skipped after the box test, one beyond unit distance inside the box after
//   the squared distance, and one within unit distance runs the serial square
//   root and the three parallel bit-serial dividers, shared by all neighbours,
//   which set its cost; they end early when all three quotients saturate.
//   Reset: rst_n low clears the queue, the engine and the gain to 1.0; the
//   position store keeps no reset and must be written before a query.
//

module pairwise_separation_force_core
  import psf_pkg::*;
#(
  parameter int unsigned NUM_BOIDS = NUM_BOIDS_DEF,
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                in_func,
  input  wire logic [IDX_W-1:0]    in_boid_index,
  input  wire logic [IN_POS_W-1:0] in_pos_x,
  input  wire logic [IN_POS_W-1:0] in_pos_y,
  input  wire logic [IN_POS_W-1:0] in_pos_z,
  output logic                     out_valid,
  output logic signed [FRC_W-1:0]  out_force_x,
  output logic signed [FRC_W-1:0]  out_force_y,
  output logic signed [FRC_W-1:0]  out_force_z,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [GAIN_W-1:0]   cfg_data
);

  logic [GAIN_W-1:0] gain_r, gain_nxt;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  // gain register
  assign cfg_ready = 1'b1;
  assign gain_nxt  = (cfg_valid && cfg_ready) ? cfg_data : gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else begin
      gain_r <= gain_nxt;
    end
  end

  psf_front #(
    .NUM_BOIDS (NUM_BOIDS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_func       (in_func),
    .in_boid_index (in_boid_index),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  psf_back #(
    .NUM_BOIDS (NUM_BOIDS),
    .POS_WIDTH (POS_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .gain        (gain_r),
    .out_valid   (out_valid),
    .out_force_x (out_force_x),
    .out_force_y (out_force_y),
    .out_force_z (out_force_z)
  );

  // results are single-cycle strobes
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // reset leaves no result pending
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !busy)
    else $error("result or busy after reset");

  // the queue only fills from an accepted transaction
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an incoming transaction");

endmodule

`default_nettype wire
